FILE: src/mieu_pkg.sv
// ----------------------------------------------------------------------------
// mieu_pkg
// shared types and codes of the integer execute unit
// ----------------------------------------------------------------------------
package mieu_pkg;

  localparam int unsigned XLEN = 32;

  // operation codes of one item
  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_ADDI  = 5'd1,
    ACT_ADDIU = 5'd2,
    ACT_ADDU  = 5'd3,
    ACT_SUB   = 5'd4,
    ACT_SUBU  = 5'd5,
    ACT_DIV   = 5'd6,
    ACT_DIVU  = 5'd7,
    ACT_MULT  = 5'd8,
    ACT_MULTU = 5'd9,
    ACT_SLL   = 5'd10,
    ACT_SLLV  = 5'd11,
    ACT_SRA   = 5'd12,
    ACT_SRAV  = 5'd13,
    ACT_SRL   = 5'd14,
    ACT_SRLV  = 5'd15,
    ACT_AND   = 5'd16,
    ACT_ANDI  = 5'd17,
    ACT_NOR   = 5'd18,
    ACT_OR    = 5'd19,
    ACT_ORI   = 5'd20,
    ACT_XOR   = 5'd21,
    ACT_XORI  = 5'd22,
    ACT_SLT   = 5'd23,
    ACT_SLTI  = 5'd24,
    ACT_SLTIU = 5'd25,
    ACT_SLTU  = 5'd26
  } act_e;

  // top level sequencer
  typedef enum logic {
    ST_IDLE,
    ST_MD_WAIT
  } ieu_state_e;

  // multiply / divide unit sequencer
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
    logic ack;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } md_rsp_t;

endpackage

FILE: src/mieu_muldiv.sv
// ----------------------------------------------------------------------------
// mieu_muldiv
// radix-2 multiply and restoring divide on one shared 33-bit adder
// ----------------------------------------------------------------------------
module mieu_muldiv import mieu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md_req_t           req_i,
  input  logic [XLEN-1:0]   a_i,
  input  logic [XLEN-1:0]   b_i,
  output md_rsp_t           rsp_o,
  output logic [XLEN-1:0]   hi_o,
  output logic [XLEN-1:0]   lo_o
);

  localparam int unsigned CW = $clog2(XLEN);

  md_state_e         state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [XLEN:0]     acc_q, acc_d;
  logic [XLEN-1:0]   low_q, low_d;
  logic [XLEN-1:0]   opnd_q, opnd_d;
  logic              is_div_q, is_div_d;
  logic              neg_lo_q, neg_lo_d;
  logic              neg_hi_q, neg_hi_d;
  logic              dz_q, dz_d;

  logic [XLEN-1:0]   a_mag, b_mag;
  logic [XLEN:0]     add_x, add_y;
  logic [XLEN+1:0]   add_sum;
  logic              carry;
  logic [2*XLEN-1:0] prod, prod_neg;

  assign a_mag = (req_i.is_signed && a_i[XLEN-1]) ? (~a_i + XLEN'(1)) : a_i;
  assign b_mag = (req_i.is_signed && b_i[XLEN-1]) ? (~b_i + XLEN'(1)) : b_i;

  // shared adder: add multiplicand or subtract divisor
  assign add_x = is_div_q ? {acc_q[XLEN-1:0], low_q[XLEN-1]} : {1'b0, acc_q[XLEN-1:0]};
  assign add_y = is_div_q ? ~{1'b0, opnd_q} :
                 (low_q[0] ? {1'b0, opnd_q} : '0);
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(XLEN+1){1'b0}}, is_div_q};
  assign carry   = add_sum[XLEN+1];

  assign prod     = {acc_q[XLEN-1:0], low_q};
  assign prod_neg = ~prod + (2*XLEN)'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_RUN;
      MD_RUN:  if (cnt_q == CW'(XLEN - 1)) state_d = MD_FIX;
      MD_FIX:  state_d = MD_DONE;
      MD_DONE: if (req_i.ack) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    low_d    = low_q;
    opnd_d   = opnd_q;
    is_div_d = is_div_q;
    neg_lo_d = neg_lo_q;
    neg_hi_d = neg_hi_q;
    dz_d     = dz_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          cnt_d    = '0;
          acc_d    = '0;
          low_d    = a_mag;
          opnd_d   = b_mag;
          is_div_d = req_i.is_div;
          neg_lo_d = req_i.is_signed && (a_i[XLEN-1] ^ b_i[XLEN-1]);
          neg_hi_d = req_i.is_signed && a_i[XLEN-1];
          dz_d     = (b_i == '0);
        end
      end
      MD_RUN: begin
        cnt_d = cnt_q + CW'(1);
        if (is_div_q) begin
          acc_d = carry ? add_sum[XLEN:0] : add_x;
          low_d = {low_q[XLEN-2:0], carry};
        end else begin
          acc_d = {1'b0, add_sum[XLEN:1]};
          low_d = {add_sum[0], low_q[XLEN-1:1]};
        end
      end
      MD_FIX: begin
        // sign correction of the magnitude result
        if (is_div_q) begin
          if (neg_lo_q) low_d = ~low_q + XLEN'(1);
          if (neg_hi_q) acc_d = {1'b0, ~acc_q[XLEN-1:0] + XLEN'(1)};
        end else if (neg_lo_q) begin
          acc_d = {1'b0, prod_neg[2*XLEN-1:XLEN]};
          low_d = prod_neg[XLEN-1:0];
        end
      end
      MD_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    low_q    <= low_d;
    opnd_q   <= opnd_d;
    is_div_q <= is_div_d;
    neg_lo_q <= neg_lo_d;
    neg_hi_q <= neg_hi_d;
    dz_q     <= dz_d;
  end

  assign rsp_o.done     = (state_q == MD_DONE);
  assign rsp_o.div_zero = dz_q;
  assign hi_o           = acc_q[XLEN-1:0];
  assign lo_o           = low_q;

endmodule

FILE: src/mips32_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// mips32_integer_execute_unit
// 32-bit integer execute stage: add/sub, logic, shifts, compares, mul/div
// ----------------------------------------------------------------------------
// One instruction per transfer. For add, subtract, logic, shift and compare
// operations the result is registered at the input transfer and offered
// on the next cycle. MULT, MULTU, DIV and DIVU go through an
// iterative unit built around one 33-bit adder that retires one bit per
// cycle: 32 steps, then a sign-correction state and a hand-over state that
// waits for a free output slot. The input stays not ready until the result
// is handed over. A new input is taken while the previous result is being
// taken on the output side. HI and LO reset to zero and change only when a
// multiply or a divide by a nonzero value completes; hi_value_o and
// lo_value_o show them as they stand after the reported instruction.
// ----------------------------------------------------------------------------
module mips32_integer_execute_unit import mieu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  action_i,
  input  logic [31:0] first_source_i,
  input  logic [31:0] second_source_i,
  input  logic [15:0] immediate_i,
  input  logic [4:0]  shift_amount_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_gpr_o,
  output logic [31:0] gpr_value_o,
  output logic        overflow_trap_o,
  output logic [31:0] hi_value_o,
  output logic [31:0] lo_value_o
);

  ieu_state_e state_q, state_d;

  // output register
  logic        out_valid_q;
  logic        write_gpr_q;
  logic [31:0] gpr_value_q;
  logic        trap_q;

  // architectural hi / lo
  logic [31:0] hi_q, lo_q;

  // control
  logic        in_xfer, out_free, is_md, load_simple, load_md;
  logic        md_div_q;
  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [31:0] md_hi, md_lo;

  // combinational datapath of the simple operations
  act_e        act;
  logic [31:0] a, b, simm, zimm;
  logic [31:0] add_op, add_res, sub_res;
  logic        add_ovf, sub_ovf;
  logic [4:0]  sh_amt;
  logic        s_wr, s_trap;
  logic [31:0] s_val;

  assign act = act_e'(action_i);
  assign a   = first_source_i;
  assign b   = second_source_i;
  assign simm = {{16{immediate_i[15]}}, immediate_i};
  assign zimm = {16'd0, immediate_i};

  // trapping forms share these adders with the wrapping forms
  assign add_op  = (act == ACT_ADD || act == ACT_ADDU) ? b : simm;
  assign add_res = a + add_op;
  assign add_ovf = ((a ^ add_res) & (add_op ^ add_res)) >> 31 != 32'd0;
  assign sub_res = a - b;
  assign sub_ovf = ((a ^ b) & (a ^ sub_res)) >> 31 != 32'd0;

  // variable shifts take the count from rs
  assign sh_amt = (act == ACT_SLLV || act == ACT_SRAV || act == ACT_SRLV) ?
                  a[4:0] : shift_amount_i;

  always_comb begin
    s_wr   = 1'b1;
    s_trap = 1'b0;
    s_val  = '0;
    case (act)
      ACT_ADD, ACT_ADDI: begin
        if (add_ovf) begin
          s_trap = 1'b1;
          s_wr   = 1'b0;
        end else begin
          s_val = add_res;
        end
      end
      ACT_ADDIU, ACT_ADDU: s_val = add_res;
      ACT_SUB: begin
        if (sub_ovf) begin
          s_trap = 1'b1;
          s_wr   = 1'b0;
        end else begin
          s_val = sub_res;
        end
      end
      ACT_SUBU:            s_val = sub_res;
      ACT_SLL, ACT_SLLV:   s_val = b << sh_amt;
      ACT_SRA, ACT_SRAV:   s_val = $unsigned($signed(b) >>> sh_amt);
      ACT_SRL, ACT_SRLV:   s_val = b >> sh_amt;
      ACT_AND:             s_val = a & b;
      ACT_ANDI:            s_val = a & zimm;
      ACT_NOR:             s_val = ~(a | b);
      ACT_OR:              s_val = a | b;
      ACT_ORI:             s_val = a | zimm;
      ACT_XOR:             s_val = a ^ b;
      ACT_XORI:            s_val = a ^ zimm;
      ACT_SLT:             s_val = {31'd0, $signed(a) < $signed(b)};
      ACT_SLTI:            s_val = {31'd0, $signed(a) < $signed(simm)};
      ACT_SLTIU:           s_val = {31'd0, a < simm};
      ACT_SLTU:            s_val = {31'd0, a < b};
      default:             s_wr  = 1'b0; // unused codes: no operation
    endcase
  end

  assign is_md = (act == ACT_DIV) || (act == ACT_DIVU) ||
                 (act == ACT_MULT) || (act == ACT_MULTU);

  // output slot is free or emptied in this cycle
  assign out_free = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_xfer && is_md) state_d = ST_MD_WAIT;
      ST_MD_WAIT: if (md_rsp.done && out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o       = 1'b0;
    load_simple      = 1'b0;
    load_md          = 1'b0;
    md_req.start     = 1'b0;
    md_req.is_div    = (act == ACT_DIV) || (act == ACT_DIVU);
    md_req.is_signed = (act == ACT_DIV) || (act == ACT_MULT);
    md_req.ack       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = out_free;
        load_simple  = in_xfer && !is_md;
        md_req.start = in_xfer && is_md;
      end
      ST_MD_WAIT: begin
        load_md    = md_rsp.done && out_free;
        md_req.ack = load_md;
      end
      default: ;
    endcase
  end

  mieu_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (a),
    .b_i    (b),
    .rsp_o  (md_rsp),
    .hi_o   (md_hi),
    .lo_o   (md_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
      md_div_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_simple || load_md) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (md_req.start) begin
        md_div_q <= md_req.is_div;
      end
      // a divide by zero leaves hi / lo alone
      if (load_md && !(md_div_q && md_rsp.div_zero)) begin
        hi_q <= md_hi;
        lo_q <= md_lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_simple) begin
      write_gpr_q <= s_wr;
      gpr_value_q <= s_val;
      trap_q      <= s_trap;
    end else if (load_md) begin
      // multiplies also write lo to the destination register
      write_gpr_q <= !md_div_q;
      gpr_value_q <= md_div_q ? 32'd0 : md_lo;
      trap_q      <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_gpr_o     = write_gpr_q;
  assign gpr_value_o     = gpr_value_q;
  assign overflow_trap_o = trap_q;
  assign hi_value_o      = hi_q;
  assign lo_value_o      = lo_q;

  // no input transfer while the mul/div unit is busy
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("input ready while mul/div in flight");

  // hi / lo only move when a mul/div result is handed over
  a_hilo_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hi_q != $past(hi_q) || lo_q != $past(lo_q)) |-> $past(load_md))
    else $error("hi/lo changed without mul/div completion");

  // a trapped instruction never writes a register
  a_trap_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_trap_o) |-> !write_gpr_o)
    else $error("trap with register write");

  // simple operations show their result on the next cycle
  a_simple_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !is_md) |=> out_valid_o)
    else $error("single-cycle result missing");

endmodule
